// ----- design/dsa_pkg.sv -----
package dsa_pkg;

    localparam int MAX_LEN = 4096;
    localparam int AW      = 12;
    localparam int LW      = 13;
    localparam int TAG_W   = 32;
    localparam int SYM_W   = 3;
    localparam int IN_W    = 56;
    localparam int OUT_W   = 72;

    localparam logic [1:0] FN_APPEND = 2'd0;
    localparam logic [1:0] FN_CLOSE  = 2'd1;
    localparam logic [1:0] FN_BUILD  = 2'd2;
    localparam logic [1:0] FN_READ   = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_RANGE   = 2'd2;
    localparam logic [1:0] ST_UNBUILT = 2'd3;

    localparam logic [SYM_W-1:0] SYM_SEP = 3'd0;
    localparam logic [SYM_W-1:0] SYM_A   = 3'd1;
    localparam logic [SYM_W-1:0] SYM_T   = 3'd2;
    localparam logic [SYM_W-1:0] SYM_C   = 3'd3;
    localparam logic [SYM_W-1:0] SYM_G   = 3'd4;

    localparam logic [LW-1:0] BASE_BUCKETS = 13'd5;

    // Maps a character byte to its base code; anything unknown counts as A.
    function automatic logic [SYM_W-1:0] code_of(input logic [7:0] ch);
        logic [SYM_W-1:0] c;
        case (ch)
            8'h54, 8'h74: c = SYM_T;
            8'h43, 8'h63: c = SYM_C;
            8'h47, 8'h67: c = SYM_G;
            default:      c = SYM_A;
        endcase
        return c;
    endfunction

endpackage

// ----- design/dsa_ram.sv -----
module dsa_ram #(
    parameter int W  = 12,
    parameter int AW = 12
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);
    logic [W-1:0] r_mem [2**AW];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- design/dna_suffix_array_lcp_builder.sv -----
// Channel   Dir  Handshake          Payload
// s_axis    in   tvalid / tready    tuser: func; tdata: symbol, tag, index
// m_axis    out  tvalid / tready    tdata: status, suffix_pos, lcp, rank_of_pos, tag_of_pos
//
// Append answers with its result beat directly; read first fetches from the memories,
// and close first tags every position not yet tagged. Build uses one read port per
// memory: a first counting sort of the n symbols, up to log2(n) doubling passes
// (rounded up), then the final ranks and the LCP scan.
// Reset clears the state, lengths and the built flag only. The input is not ready
// while a command runs or its result beat is stalled.
module dna_suffix_array_lcp_builder import dsa_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  logic [IN_W-1:0]  i_s_axis_tdata,  // symbol[7:0], tag[39:8], index[51:40]
    input  logic [1:0]       i_s_axis_tuser,  // func[1:0]
    output logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    output logic [OUT_W-1:0] o_m_axis_tdata   // status, suffix_pos, lcp, rank_of_pos, tag_of_pos
);
    localparam logic [5:0] S_IDLE = 6'd0,  S_TAGW = 6'd1,  S_RD   = 6'd2,  S_OUT  = 6'd3;
    localparam logic [5:0] S_IN1  = 6'd4,  S_IN2  = 6'd5,  S_BCL  = 6'd6,  S_BC1  = 6'd7;
    localparam logic [5:0] S_BC2  = 6'd8,  S_BC3  = 6'd9,  S_BPR1 = 6'd10, S_BPR2 = 6'd11;
    localparam logic [5:0] S_BP1  = 6'd12, S_BP2  = 6'd13, S_BP3  = 6'd14, S_DST  = 6'd15;
    localparam logic [5:0] S_G1   = 6'd16, S_G2A  = 6'd17, S_G2B  = 6'd18, S_G3A  = 6'd19;
    localparam logic [5:0] S_G3B  = 6'd20, S_G3C  = 6'd21, S_CP1  = 6'd22, S_CP2  = 6'd23;
    localparam logic [5:0] S_RK0A = 6'd24, S_RK0B = 6'd25, S_R1   = 6'd26, S_R2   = 6'd27;
    localparam logic [5:0] S_R3   = 6'd28, S_R4   = 6'd29, S_R5   = 6'd30, S_R6   = 6'd31;
    localparam logic [5:0] S_F1   = 6'd32, S_F2   = 6'd33, S_K1   = 6'd34, S_K2   = 6'd35;
    localparam logic [5:0] S_K3   = 6'd36, S_K4   = 6'd37, S_K5   = 6'd38, S_K6   = 6'd39;
    localparam logic [5:0] S_DONE = 6'd40;

    logic [5:0]       r_state, n_state, r_ret, n_ret;
    logic [LW-1:0]    r_len, n_len, r_tlen, n_tlen;
    logic             r_built, n_built;
    logic [LW-1:0]    r_i, n_i, r_q, n_q, r_k, n_k, r_p, n_p, r_m, n_m;
    logic [LW-1:0]    r_bk, n_bk, r_acc, n_acc, r_h, n_h;
    logic [AW-1:0]    r_a, n_a, r_b, n_b, r_ta, n_ta, r_tb, n_tb, r_tak, n_tak;
    logic [AW-1:0]    r_key, n_key, r_val, n_val, r_r, n_r, r_j, n_j, r_idx, n_idx;
    logic [SYM_W-1:0] r_si, n_si;
    logic [TAG_W-1:0] r_tag, n_tag;
    logic [1:0]       r_o_status, n_o_status;
    logic [AW-1:0]    r_o_spos, n_o_spos, r_o_rank, n_o_rank;
    logic [LW-1:0]    r_o_lcp, n_o_lcp;
    logic [TAG_W-1:0] r_o_tag, n_o_tag;

    logic             sym_we, tag_we, sa_we, rank_we, tmp_we, key_we, cnt_we, lcp_we;
    logic [AW-1:0]    sym_wa, tag_wa, sa_wa, rank_wa, tmp_wa, key_wa, cnt_wa, lcp_wa;
    logic [AW-1:0]    sym_ra, tag_ra, sa_ra, rank_ra, tmp_ra, key_ra, cnt_ra, lcp_ra;
    logic [SYM_W-1:0] sym_wd, sym_rd;
    logic [TAG_W-1:0] tag_wd, tag_rd;
    logic [AW-1:0]    sa_wd, sa_rd, rank_wd, rank_rd, tmp_wd, tmp_rd, key_wd, key_rd;
    logic [LW-1:0]    cnt_wd, cnt_rd, lcp_wd, lcp_rd;

    logic [1:0]       in_func;
    logic [7:0]       in_sym;
    logic [TAG_W-1:0] in_tag;
    logic [AW-1:0]    in_idx;
    logic [LW:0]      ak, bk, ih, jh;
    logic             ea, eb, same;
    logic [LW-1:0]    cdec;

    assign in_sym  = i_s_axis_tdata[7:0];
    assign in_tag  = i_s_axis_tdata[39:8];
    assign in_idx  = i_s_axis_tdata[51:40];
    assign in_func = i_s_axis_tuser;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = (r_state == S_OUT);
    assign o_m_axis_tdata  = {1'b0, r_o_tag, r_o_rank, r_o_lcp, r_o_spos, r_o_status};

    assign ak   = {2'b00, r_a} + {1'b0, r_k};
    assign bk   = {2'b00, r_b} + {1'b0, r_k};
    assign ih   = {1'b0, r_i} + {1'b0, r_h};
    assign jh   = {2'b00, r_j} + {1'b0, r_h};
    assign ea   = ak >= {1'b0, r_len};
    assign eb   = bk >= {1'b0, r_len};
    assign same = (r_ta == r_tb) && ((ea || eb) ? (ea && eb) : (r_tak == tmp_rd));
    assign cdec = cnt_rd - 13'd1;

    always_comb begin
        n_state = r_state;  n_ret = r_ret;  n_len = r_len;  n_tlen = r_tlen;
        n_built = r_built;  n_i = r_i;  n_q = r_q;  n_k = r_k;  n_p = r_p;  n_m = r_m;
        n_bk = r_bk;  n_acc = r_acc;  n_h = r_h;  n_a = r_a;  n_b = r_b;  n_ta = r_ta;
        n_tb = r_tb;  n_tak = r_tak;  n_key = r_key;  n_val = r_val;  n_r = r_r;
        n_j = r_j;  n_idx = r_idx;  n_si = r_si;  n_tag = r_tag;
        n_o_status = r_o_status;  n_o_spos = r_o_spos;  n_o_lcp = r_o_lcp;
        n_o_rank = r_o_rank;  n_o_tag = r_o_tag;
        sym_we = 1'b0; sym_wa = '0; sym_wd = '0; sym_ra = '0;
        tag_we = 1'b0; tag_wa = '0; tag_wd = '0; tag_ra = '0;
        sa_we = 1'b0; sa_wa = '0; sa_wd = '0; sa_ra = '0;
        rank_we = 1'b0; rank_wa = '0; rank_wd = '0; rank_ra = '0;
        tmp_we = 1'b0; tmp_wa = '0; tmp_wd = '0; tmp_ra = '0;
        key_we = 1'b0; key_wa = '0; key_wd = '0; key_ra = '0;
        cnt_we = 1'b0; cnt_wa = '0; cnt_wd = '0; cnt_ra = '0;
        lcp_we = 1'b0; lcp_wa = '0; lcp_wd = '0; lcp_ra = '0;

        case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_o_status = ST_OK; n_o_spos = '0; n_o_lcp = '0;
                    n_o_rank = '0; n_o_tag = '0;
                    n_tag = in_tag; n_idx = in_idx;
                    n_state = S_OUT;
                    case (in_func)
                        FN_APPEND: begin
                            if (r_len >= LW'(MAX_LEN - 1)) begin
                                n_o_status = ST_FULL;
                            end else begin
                                sym_we = 1'b1; sym_wa = r_len[AW-1:0]; sym_wd = code_of(in_sym);
                                n_len = r_len + 13'd1; n_built = 1'b0;
                            end
                        end
                        FN_CLOSE: begin
                            if (r_len >= LW'(MAX_LEN)) begin
                                n_o_status = ST_FULL;
                            end else begin
                                sym_we = 1'b1; sym_wa = r_len[AW-1:0]; sym_wd = SYM_SEP;
                                n_len = r_len + 13'd1; n_built = 1'b0;
                                n_state = S_TAGW;
                            end
                        end
                        FN_BUILD: begin
                            n_i = '0;
                            n_state = (r_len == '0) ? S_DONE : S_IN1;
                        end
                        default: begin
                            sa_ra = in_idx; rank_ra = in_idx; lcp_ra = in_idx; tag_ra = in_idx;
                            if (!r_built) begin
                                n_o_status = ST_UNBUILT;
                            end else if ({1'b0, in_idx} >= r_len) begin
                                n_o_status = ST_RANGE;
                            end else begin
                                n_state = S_RD;
                            end
                        end
                    endcase
                end
            end
            S_TAGW: begin
                if (r_tlen == r_len) begin
                    n_state = S_OUT;
                end else begin
                    tag_we = 1'b1; tag_wa = r_tlen[AW-1:0]; tag_wd = r_tag;
                    n_tlen = r_tlen + 13'd1;
                end
            end
            S_RD: begin
                n_o_spos = sa_rd; n_o_lcp = lcp_rd; n_o_rank = rank_rd;
                n_o_tag  = ({1'b0, r_idx} < r_tlen) ? tag_rd : '0;
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (i_m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end
            S_IN1: begin
                if (r_i == r_len) begin
                    n_m = BASE_BUCKETS; n_p = 13'd1; n_k = 13'd1;
                    n_bk = BASE_BUCKETS; n_ret = S_DST; n_i = '0; n_state = S_BCL;
                end else begin
                    sym_ra = r_i[AW-1:0]; n_state = S_IN2;
                end
            end
            S_IN2: begin
                rank_we = 1'b1; rank_wa = r_i[AW-1:0]; rank_wd = AW'(sym_rd);
                tmp_we = 1'b1;  tmp_wa = r_i[AW-1:0];  tmp_wd = r_i[AW-1:0];
                key_we = 1'b1;  key_wa = r_i[AW-1:0];  key_wd = AW'(sym_rd);
                n_i = r_i + 13'd1; n_state = S_IN1;
            end
            // Counting sort of the order in tmp by key, into the suffix order.
            S_BCL: begin
                cnt_we = 1'b1; cnt_wa = r_i[AW-1:0]; cnt_wd = '0;
                if (r_i == r_bk) begin
                    n_i = '0; n_state = S_BC1;
                end else begin
                    n_i = r_i + 13'd1;
                end
            end
            S_BC1: begin
                if (r_i == r_len) begin
                    n_i = '0; n_acc = '0; n_state = S_BPR1;
                end else begin
                    key_ra = r_i[AW-1:0]; n_state = S_BC2;
                end
            end
            S_BC2: begin
                cnt_ra = key_rd; n_key = key_rd; n_state = S_BC3;
            end
            S_BC3: begin
                cnt_we = 1'b1; cnt_wa = r_key; cnt_wd = cnt_rd + 13'd1;
                n_i = r_i + 13'd1; n_state = S_BC1;
            end
            S_BPR1: begin
                cnt_ra = r_i[AW-1:0]; n_state = S_BPR2;
            end
            S_BPR2: begin
                cnt_we = 1'b1; cnt_wa = r_i[AW-1:0]; cnt_wd = r_acc + cnt_rd;
                n_acc = r_acc + cnt_rd;
                if (r_i == r_bk) begin
                    n_i = r_len; n_state = S_BP1;
                end else begin
                    n_i = r_i + 13'd1; n_state = S_BPR1;
                end
            end
            S_BP1: begin
                if (r_i == '0) begin
                    n_state = r_ret;
                end else begin
                    key_ra = AW'(r_i - 13'd1); tmp_ra = AW'(r_i - 13'd1); n_state = S_BP2;
                end
            end
            S_BP2: begin
                cnt_ra = key_rd; n_key = key_rd; n_val = tmp_rd; n_state = S_BP3;
            end
            S_BP3: begin
                cnt_we = 1'b1; cnt_wa = r_key; cnt_wd = cdec;
                sa_we = 1'b1; sa_wa = cdec[AW-1:0]; sa_wd = r_val;
                n_i = r_i - 13'd1; n_state = S_BP1;
            end
            // One doubling pass: order by second key, sort by first, rerank.
            S_DST: begin
                if (r_p >= r_len) begin
                    n_i = '0; n_state = S_F1;
                end else begin
                    n_q = '0;
                    n_i = (r_k < r_len) ? r_len - r_k : '0;
                    n_state = S_G1;
                end
            end
            S_G1: begin
                if (r_i == r_len) begin
                    n_i = '0; n_state = S_G2A;
                end else begin
                    tmp_we = 1'b1; tmp_wa = r_q[AW-1:0]; tmp_wd = r_i[AW-1:0];
                    n_q = r_q + 13'd1; n_i = r_i + 13'd1;
                end
            end
            S_G2A: begin
                if (r_i == r_len) begin
                    n_i = '0; n_state = S_G3A;
                end else begin
                    sa_ra = r_i[AW-1:0]; n_state = S_G2B;
                end
            end
            S_G2B: begin
                if ({1'b0, sa_rd} >= r_k) begin
                    tmp_we = 1'b1; tmp_wa = r_q[AW-1:0];
                    tmp_wd = AW'({1'b0, sa_rd} - r_k);
                    n_q = r_q + 13'd1;
                end
                n_i = r_i + 13'd1; n_state = S_G2A;
            end
            S_G3A: begin
                if (r_i == r_len) begin
                    n_bk = r_m; n_ret = S_CP1; n_i = '0; n_state = S_BCL;
                end else begin
                    tmp_ra = r_i[AW-1:0]; n_state = S_G3B;
                end
            end
            S_G3B: begin
                rank_ra = tmp_rd; n_state = S_G3C;
            end
            S_G3C: begin
                key_we = 1'b1; key_wa = r_i[AW-1:0]; key_wd = rank_rd;
                n_i = r_i + 13'd1; n_state = S_G3A;
            end
            S_CP1: begin
                if (r_i == r_len) begin
                    n_state = S_RK0A;
                end else begin
                    rank_ra = r_i[AW-1:0]; n_state = S_CP2;
                end
            end
            S_CP2: begin
                tmp_we = 1'b1; tmp_wa = r_i[AW-1:0]; tmp_wd = rank_rd;
                n_i = r_i + 13'd1; n_state = S_CP1;
            end
            S_RK0A: begin
                sa_ra = '0; n_state = S_RK0B;
            end
            S_RK0B: begin
                rank_we = 1'b1; rank_wa = sa_rd; rank_wd = '0;
                n_a = sa_rd; n_p = 13'd1; n_i = 13'd1; n_state = S_R1;
            end
            S_R1: begin
                if (r_i == r_len) begin
                    n_m = r_p; n_k = {r_k[LW-2:0], 1'b0}; n_state = S_DST;
                end else begin
                    sa_ra = r_i[AW-1:0]; n_state = S_R2;
                end
            end
            S_R2: begin
                n_b = sa_rd; tmp_ra = r_a; n_state = S_R3;
            end
            S_R3: begin
                n_ta = tmp_rd; tmp_ra = r_b; n_state = S_R4;
            end
            S_R4: begin
                n_tb = tmp_rd; tmp_ra = ak[AW-1:0]; n_state = S_R5;
            end
            S_R5: begin
                n_tak = tmp_rd; tmp_ra = bk[AW-1:0]; n_state = S_R6;
            end
            S_R6: begin
                rank_we = 1'b1; rank_wa = r_b;
                rank_wd = same ? AW'(r_p - 13'd1) : r_p[AW-1:0];
                if (!same) begin
                    n_p = r_p + 13'd1;
                end
                n_a = r_b; n_i = r_i + 13'd1; n_state = S_R1;
            end
            S_F1: begin
                if (r_i == r_len) begin
                    n_i = '0; n_h = '0; n_state = S_K1;
                end else begin
                    sa_ra = r_i[AW-1:0]; n_state = S_F2;
                end
            end
            S_F2: begin
                rank_we = 1'b1; rank_wa = sa_rd; rank_wd = r_i[AW-1:0];
                n_i = r_i + 13'd1; n_state = S_F1;
            end
            // Kasai scan over positions; h carries over minus one.
            S_K1: begin
                if (r_i == r_len) begin
                    n_state = S_DONE;
                end else begin
                    rank_ra = r_i[AW-1:0]; n_state = S_K2;
                end
            end
            S_K2: begin
                n_r = rank_rd;
                if (rank_rd == '0) begin
                    lcp_we = 1'b1; lcp_wa = '0; lcp_wd = '0;
                    n_h = '0; n_i = r_i + 13'd1; n_state = S_K1;
                end else begin
                    sa_ra = rank_rd - 12'd1; n_state = S_K3;
                end
            end
            S_K3: begin
                n_j = sa_rd; n_state = S_K4;
            end
            S_K4: begin
                if (ih < {1'b0, r_len} && jh < {1'b0, r_len}) begin
                    sym_ra = ih[AW-1:0]; n_state = S_K5;
                end else begin
                    lcp_we = 1'b1; lcp_wa = r_r; lcp_wd = r_h;
                    n_h = (r_h != '0) ? r_h - 13'd1 : '0;
                    n_i = r_i + 13'd1; n_state = S_K1;
                end
            end
            S_K5: begin
                n_si = sym_rd; sym_ra = jh[AW-1:0]; n_state = S_K6;
            end
            S_K6: begin
                if (sym_rd == r_si) begin
                    n_h = r_h + 13'd1; n_state = S_K4;
                end else begin
                    lcp_we = 1'b1; lcp_wa = r_r; lcp_wd = r_h;
                    n_h = (r_h != '0) ? r_h - 13'd1 : '0;
                    n_i = r_i + 13'd1; n_state = S_K1;
                end
            end
            S_DONE: begin
                n_built = 1'b1; n_state = S_OUT;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_len   <= '0;
            r_tlen  <= '0;
            r_built <= 1'b0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
            r_tlen  <= n_tlen;
            r_built <= n_built;
        end
        r_ret <= n_ret;  r_i <= n_i;  r_q <= n_q;  r_k <= n_k;  r_p <= n_p;  r_m <= n_m;
        r_bk <= n_bk;  r_acc <= n_acc;  r_h <= n_h;  r_a <= n_a;  r_b <= n_b;
        r_ta <= n_ta;  r_tb <= n_tb;  r_tak <= n_tak;  r_key <= n_key;  r_val <= n_val;
        r_r <= n_r;  r_j <= n_j;  r_idx <= n_idx;  r_si <= n_si;  r_tag <= n_tag;
        r_o_status <= n_o_status;  r_o_spos <= n_o_spos;  r_o_lcp <= n_o_lcp;
        r_o_rank <= n_o_rank;  r_o_tag <= n_o_tag;
    end

    dsa_ram #(.W(SYM_W), .AW(AW)) u_sym (.i_clk(i_clk), .i_we(sym_we), .i_waddr(sym_wa),
        .i_wdata(sym_wd), .i_raddr(sym_ra), .o_rdata(sym_rd));
    dsa_ram #(.W(TAG_W), .AW(AW)) u_tag (.i_clk(i_clk), .i_we(tag_we), .i_waddr(tag_wa),
        .i_wdata(tag_wd), .i_raddr(tag_ra), .o_rdata(tag_rd));
    dsa_ram #(.W(AW), .AW(AW)) u_sa (.i_clk(i_clk), .i_we(sa_we), .i_waddr(sa_wa),
        .i_wdata(sa_wd), .i_raddr(sa_ra), .o_rdata(sa_rd));
    dsa_ram #(.W(AW), .AW(AW)) u_rank (.i_clk(i_clk), .i_we(rank_we), .i_waddr(rank_wa),
        .i_wdata(rank_wd), .i_raddr(rank_ra), .o_rdata(rank_rd));
    dsa_ram #(.W(AW), .AW(AW)) u_tmp (.i_clk(i_clk), .i_we(tmp_we), .i_waddr(tmp_wa),
        .i_wdata(tmp_wd), .i_raddr(tmp_ra), .o_rdata(tmp_rd));
    dsa_ram #(.W(AW), .AW(AW)) u_key (.i_clk(i_clk), .i_we(key_we), .i_waddr(key_wa),
        .i_wdata(key_wd), .i_raddr(key_ra), .o_rdata(key_rd));
    dsa_ram #(.W(LW), .AW(AW)) u_cnt (.i_clk(i_clk), .i_we(cnt_we), .i_waddr(cnt_wa),
        .i_wdata(cnt_wd), .i_raddr(cnt_ra), .o_rdata(cnt_rd));
    dsa_ram #(.W(LW), .AW(AW)) u_lcp (.i_clk(i_clk), .i_we(lcp_we), .i_waddr(lcp_wa),
        .i_wdata(lcp_wd), .i_raddr(lcp_ra), .o_rdata(lcp_rd));

    a_no_accept_while_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !o_s_axis_tready)
        else $error("input ready while a result beat is pending");
    a_tag_within_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tlen <= r_len)
        else $error("tagged length ran past data length");
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LW'(MAX_LEN))
        else $error("data length over capacity");
    a_done_sets_built: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |=> (r_built && o_m_axis_tvalid))
        else $error("build finished without setting built flag");
endmodule

// ----- test/dna_suffix_array_lcp_builder_test.sv -----
`timescale 1ns / 100ps

module dna_suffix_array_lcp_builder_test;
    import dsa_pkg::*;

    typedef struct packed {
        logic [31:0] tag_of_pos;
        logic [11:0] rank_of_pos;
        logic [12:0] lcp;
        logic [11:0] suffix_pos;
        logic [1:0]  status;
    } t_result;

    class t_lcp_scoreboard;
        logic [2:0]   sym_mem [MAX_LEN];
        logic [31:0]  tag_mem [MAX_LEN];
        int unsigned  order [MAX_LEN];
        int unsigned  rnk [MAX_LEN];
        int unsigned  second [MAX_LEN];
        int unsigned  keys [MAX_LEN];
        int unsigned  counts [MAX_LEN + 1];
        int unsigned  heights [MAX_LEN];
        int unsigned  len;
        int unsigned  tag_len;
        bit           built;
        t_result      pending [$];
        int           errors;
        int           reads_ok;
        int           builds;

        function new();
            len = 0;
            tag_len = 0;
            built = 0;
            errors = 0;
            reads_ok = 0;
            builds = 0;
        endfunction

        function logic [2:0] base_code(logic [7:0] ch);
            case (ch)
                "T", "t": return SYM_T;
                "C", "c": return SYM_C;
                "G", "g": return SYM_G;
                default:  return SYM_A;
            endcase
        endfunction

        // Stable counting sort: order[] gets second[] sorted by keys[].
        function void counting_sort(int unsigned n, int unsigned nb);
            for (int unsigned i = 0; i <= nb; i++) counts[i] = 0;
            for (int unsigned i = 0; i < n; i++) counts[keys[i]]++;
            for (int unsigned i = 0; i < nb; i++) counts[i + 1] += counts[i];
            for (int unsigned i = n; i > 0; i--) begin
                counts[keys[i - 1]]--;
                order[counts[keys[i - 1]]] = second[i - 1];
            end
        endfunction

        function void build_arrays();
            int unsigned n, k, p, q, m, a, b, r, j, h;
            bit same, ea, eb;
            n = len;
            if (n == 0) return;
            for (int unsigned i = 0; i < n; i++) begin
                rnk[i] = 32'(sym_mem[i]);
                second[i] = i;
                keys[i] = 32'(sym_mem[i]);
            end
            counting_sort(n, 5);
            m = 5;
            p = 1;
            for (k = 1; p < n; k <<= 1) begin
                q = 0;
                for (int unsigned i = (k < n) ? n - k : 0; i < n; i++) begin
                    second[q] = i;
                    q++;
                end
                for (int unsigned i = 0; i < n; i++)
                    if (order[i] >= k) begin
                        second[q] = order[i] - k;
                        q++;
                    end
                for (int unsigned i = 0; i < n; i++) keys[i] = rnk[second[i]];
                counting_sort(n, m);
                for (int unsigned i = 0; i < n; i++) second[i] = rnk[i];
                rnk[order[0]] = 0;
                p = 1;
                for (int unsigned i = 1; i < n; i++) begin
                    a = order[i - 1];
                    b = order[i];
                    same = second[a] == second[b];
                    if (same) begin
                        // A suffix that runs off the end ranks below everything.
                        ea = a + k >= n;
                        eb = b + k >= n;
                        if (ea || eb) same = ea && eb;
                        else same = second[a + k] == second[b + k];
                    end
                    if (same) rnk[b] = p - 1;
                    else begin
                        rnk[b] = p;
                        p++;
                    end
                end
                m = p;
            end
            for (int unsigned i = 0; i < n; i++) rnk[order[i]] = i;
            h = 0;
            for (int unsigned i = 0; i < n; i++) begin
                r = rnk[i];
                if (r == 0) begin
                    heights[0] = 0;
                    h = 0;
                    continue;
                end
                j = order[r - 1];
                while (i + h < n && j + h < n && sym_mem[i + h] == sym_mem[j + h]) h++;
                heights[r] = h;
                if (h > 0) h--;
            end
        endfunction

        function void note_command(logic [1:0] fn, logic [7:0] ch, logic [31:0] tg,
                                   logic [11:0] idx);
            t_result res;
            res = '0;
            case (fn)
                FN_APPEND: begin
                    if (len + 1 >= MAX_LEN) res.status = ST_FULL;
                    else begin
                        sym_mem[len] = base_code(ch);
                        len++;
                        built = 0;
                    end
                end
                FN_CLOSE: begin
                    if (len >= MAX_LEN) res.status = ST_FULL;
                    else begin
                        sym_mem[len] = SYM_SEP;
                        len++;
                        while (tag_len < len) begin
                            tag_mem[tag_len] = tg;
                            tag_len++;
                        end
                        built = 0;
                    end
                end
                FN_BUILD: begin
                    build_arrays();
                    built = 1;
                    builds++;
                end
                default: begin
                    if (!built) res.status = ST_UNBUILT;
                    else if (idx >= len) res.status = ST_RANGE;
                    else begin
                        res.suffix_pos = 12'(order[idx]);
                        res.lcp = 13'(heights[idx]);
                        res.rank_of_pos = 12'(rnk[idx]);
                        res.tag_of_pos = (idx < tag_len) ? tag_mem[idx] : '0;
                        reads_ok++;
                    end
                end
            endcase
            pending = {pending, res};
        endfunction

        function void check_beat(logic [OUT_W-1:0] data);
            t_result got, want;
            got = data[$bits(t_result)-1:0];
            if (pending.size() == 0) begin
                $error("result beat with nothing expected: %h", data);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.suffix_pos !== want.suffix_pos) begin
                $error("suffix_pos: expected %0d, got %0d", want.suffix_pos, got.suffix_pos);
                errors++;
            end
            if (got.lcp !== want.lcp) begin
                $error("lcp: expected %0d, got %0d", want.lcp, got.lcp);
                errors++;
            end
            if (got.rank_of_pos !== want.rank_of_pos) begin
                $error("rank_of_pos: expected %0d, got %0d", want.rank_of_pos,
                       got.rank_of_pos);
                errors++;
            end
            if (got.tag_of_pos !== want.tag_of_pos) begin
                $error("tag_of_pos: expected %h, got %h", want.tag_of_pos, got.tag_of_pos);
                errors++;
            end
        endfunction
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             i_s_axis_tvalid;
    logic             o_s_axis_tready;
    logic [IN_W-1:0]  i_s_axis_tdata;  // symbol[7:0], tag[39:8], index[51:40]
    logic [1:0]       i_s_axis_tuser;  // func[1:0]
    logic             o_m_axis_tvalid;
    logic             i_m_axis_tready = 1'b0;
    logic [OUT_W-1:0] o_m_axis_tdata;  // status, suffix_pos, lcp, rank_of_pos, tag_of_pos

    t_lcp_scoreboard sb;
    int              cycles = 0;
    int              sent;
    bit              no_gaps;
    int              stall_left = 0;
    int              wait_cycles;

    dna_suffix_array_lcp_builder DUT (.*);

    initial i_clk = 0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 10000000) begin
            $display("status: fail");
            $finish;
        end
    end

    // Result side: checks each beat and may then pull ready low before taking the next.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            sb.check_beat(o_m_axis_tdata);
            wait_cycles = $urandom_range(0, 9);
            if (wait_cycles > 0) begin
                stall_left <= wait_cycles - 1;
                i_m_axis_tready <= 1'b0;
            end
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    task automatic send(logic [1:0] fn, logic [7:0] ch, logic [31:0] tg, logic [11:0] idx);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser <= fn;
        i_s_axis_tdata <= {4'b0, idx, tg, ch};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        sb.note_command(fn, ch, tg, idx);
        sent++;
    endtask

    task automatic read_at(logic [11:0] idx);
        send(FN_READ, 8'($urandom), $urandom, idx);
    endtask

    task automatic put_string(int n, logic [31:0] tg, bit do_close);
        byte bases [4] = '{"A", "T", "C", "G"};
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 5) == 0) begin
                send(FN_APPEND, 8'($urandom), $urandom, 12'($urandom));
            end else begin
                send(FN_APPEND, 8'(bases[$urandom_range(0, 3)] | ($urandom_range(0, 1) << 5)),
                     $urandom, 12'($urandom));
            end
        end
        if (do_close) send(FN_CLOSE, 8'($urandom), tg, 12'($urandom));
    endtask

    initial begin
        byte chars [12] = '{"A", "a", "T", "t", "C", "c", "G", "g", "N", 8'hFF, 8'h00, "x"};
        sb = new();
        sent = 0;
        no_gaps = 0;
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_s_axis_tuser = FN_APPEND;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: unbuilt read, empty build, every character class, empty string,
        // extreme tags, an open string at build time and out-of-range reads.
        read_at(12'd0);
        send(FN_BUILD, 8'h00, 32'h0, 12'h0);
        read_at(12'd0);
        read_at(12'hFFF);
        foreach (chars[i]) send(FN_APPEND, chars[i], 32'h0, 12'h0);
        send(FN_CLOSE, 8'hFF, 32'hFFFF_FFFF, 12'hFFF);
        send(FN_CLOSE, 8'h00, 32'h0, 12'h0);
        send(FN_APPEND, "G", 32'h0, 12'h0);
        send(FN_APPEND, "A", 32'h0, 12'h0);
        send(FN_BUILD, 8'h00, 32'h0, 12'h0);
        for (int i = 0; i < 16; i++) read_at(12'(i));
        read_at(12'hFFF);

        // Random sessions: a few strings, a build, then a burst of reads.
        while (sent < 1660) begin
            if ($urandom_range(0, 3) == 0) read_at(12'($urandom));
            repeat ($urandom_range(0, 3)) begin
                put_string($urandom_range(0, 6), $urandom, $urandom_range(0, 4) != 0);
            end
            send(FN_BUILD, 8'($urandom), $urandom, 12'($urandom));
            repeat ($urandom_range(20, 40)) begin
                if ($urandom_range(0, 9) == 0) read_at(12'($urandom));
                else read_at(12'($urandom_range(0, sb.len - 1)));
            end
        end

        // A back-to-back burst, then a build and reads near the end of the store.
        no_gaps = 1;
        put_string(8, 32'hA5A5_0F0F, 1'b1);
        send(FN_BUILD, 8'h00, 32'h0, 12'h0);
        for (int i = 0; i < 4; i++) read_at(12'(sb.len - 1 - i));
        no_gaps = 0;
        send(FN_APPEND, "T", 32'h0, 12'h0);
        read_at(12'd5);
        i_s_axis_tvalid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        $display("Sent %0d commands with %0d builds; %0d reads returned data.",
                 sent, sb.builds, sb.reads_ok);
        $display("Covered empty strings, open strings at build, range errors and a burst.");
        if (sb.errors == 0 && sb.pending.size() == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end

endmodule
